FILE: rtl/nsr_pkg.sv
// Shared constants, types and saturation helper for the stencil residual block.
`default_nettype none

package nsr_pkg;

    // Grid limits and derived index widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 11;
    localparam int SCALE_W    = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    // Stream widths: tdata = residual, row_index, column_index (LSB first), byte padded
    localparam int S_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_W + ROW_W + COL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_ROW_LSB  = DATA_W;
    localparam int M_COL_LSB  = DATA_W + ROW_W;

    // Register reset values
    localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = SIZE_W'(8);
    localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = SIZE_W'(8);
    localparam logic [SCALE_W-1:0] SCALE_X_RST     = SCALE_W'(49);
    localparam logic [SCALE_W-1:0] SCALE_Y_RST     = SCALE_W'(49);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_SCALE_X     = 2'd2,
        REG_SCALE_Y     = 2'd3
    } cfg_reg_t;

    // One result beat
    typedef struct packed {
        logic                     grid_done;
        logic                     run_last;
        logic [COL_W-1:0]         column_index;
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] residual;
    } result_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [55:0] v);
        logic signed [55:0] hi;
        logic signed [55:0] lo;
        hi = 56'sh0000_007F_FFFF_FF;
        lo = -56'sh0000_0080_0000_00;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = -32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nonlinear_stencil_residual.sv
// Top level: streaming five-point nonlinear stencil residual over two line memories.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[31:0] sample
//  m_*       out  m_tvalid/m_tready  m_tdata residual,row_index,column_index; m_tlast; m_tuser
//  cfg_*     in   cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// Each sample passes the read of the two line memories plus a five-stage
// arithmetic path (difference, products, saturation, products, combine), one sample in flight.
// Each sample yields zero, one or two result beats through a 4-entry output queue,
// so a new sample is taken only while at most two results wait in it.
// Reset is synchronous; it clears counters, config and queue, not the line memories.
`default_nettype none

module nonlinear_stencil_residual
    import nsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] residual, [41:32] row_index,
                                                  // [51:42] column_index, [55:52] zero
    output logic                       m_tlast,   // run_last
    output logic [0:0]                 m_tuser    // [0] grid_done
);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Per-sample control and payload carried down the pipeline
    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic                     emit_above;
        logic                     emit_own;
        logic                     boundary;
        logic                     last_col;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] center;
    } item_t;

    // Configuration registers
    logic [SIZE_W-1:0]  grid_width_reg;
    logic [SIZE_W-1:0]  grid_height_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            scale_x_reg     <= SCALE_X_RST;
            scale_y_reg     <= SCALE_Y_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SCALE_X:     scale_x_reg     <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:     scale_y_reg     <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline and queue control
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [Q_AW:0]       q_count_reg, q_count_next;
    logic [Q_AW-1:0]     q_head_reg, q_tail_reg;
    logic                busy;
    logic                accept;
    logic                pop;

    assign busy     = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg | s5_valid_reg;
    assign s_tready = !busy && (q_count_reg <= (Q_AW + 1)'(Q_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    // Clamped grid size
    logic [SIZE_W-1:0] w_clamp, h_clamp;

    always_comb begin
        if (grid_width_reg < SIZE_W'(3)) begin
            w_clamp = SIZE_W'(3);
        end else if (grid_width_reg > SIZE_W'(MAX_WIDTH)) begin
            w_clamp = SIZE_W'(MAX_WIDTH);
        end else begin
            w_clamp = grid_width_reg;
        end
        if (grid_height_reg < SIZE_W'(3)) begin
            h_clamp = SIZE_W'(3);
        end else if (grid_height_reg > SIZE_W'(MAX_HEIGHT)) begin
            h_clamp = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_clamp = grid_height_reg;
        end
    end

    // Raster position of the incoming sample
    logic [COL_W-1:0]  col_reg, col_next, col_cur;
    logic [ROW_W-1:0]  row_reg, row_next, row_cur;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic              last_col, last_row;

    always_comb begin
        col_cur  = (SIZE_W'(col_reg) >= w_clamp) ? '0 : col_reg;
        row_cur  = (SIZE_W'(row_reg) >= h_clamp) ? '0 : row_reg;
        col_inc  = SIZE_W'(col_cur) + SIZE_W'(1);
        row_inc  = SIZE_W'(row_cur) + SIZE_W'(1);
        last_col = (col_inc >= w_clamp);
        last_row = (row_inc >= h_clamp);
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memories: previous row and the row before it
    logic [DATA_W-1:0] above_mem     [MAX_WIDTH];
    logic [DATA_W-1:0] two_above_mem [MAX_WIDTH];
    logic [DATA_W-1:0] rd_center_reg, rd_right_reg, rd_up_reg;
    item_t             s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;

    // Read center and right neighbor on accept; write back the new column in stage 1
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_center_reg <= above_mem[col_cur];
            rd_right_reg  <= above_mem[col_inc[COL_W-1:0]];
        end
        if (s1_valid_reg) begin
            above_mem[s1_reg.col] <= s1_reg.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_up_reg <= two_above_mem[col_cur];
        end
        if (s1_valid_reg) begin
            two_above_mem[s1_reg.col] <= rd_center_reg;
        end
    end

    // Left neighbor: center of the previous column
    logic signed [DATA_W-1:0] left_center_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_center_reg <= '0;
        end else if (s1_valid_reg) begin
            left_center_reg <= rd_center_reg;
        end
    end

    // Valid chain; one sample in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 0: capture position and flags
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.col        <= col_cur;
            s1_reg.row        <= row_cur;
            s1_reg.emit_above <= (row_cur != '0);
            s1_reg.emit_own   <= last_row;
            s1_reg.boundary   <= (col_cur == '0) || last_col || (row_cur == ROW_W'(1));
            s1_reg.last_col   <= last_col;
            s1_reg.sample     <= $signed(s_tdata[DATA_W-1:0]);
            s1_reg.center     <= '0;
        end
    end

    // Stage 1: second differences and first differences
    logic signed [DATA_W-1:0] c_s1, r_s1, up_s1, dn_s1;
    logic signed [34:0]       ax_s1, ay_s1;
    logic signed [32:0]       dx_raw, dy_raw;
    logic signed [DATA_W-1:0] dx_sat, dy_sat;
    logic signed [34:0]       ax_reg, ay_reg;
    logic [DATA_W-1:0]        dx_mag_reg, dy_mag_reg;

    always_comb begin
        c_s1   = $signed(rd_center_reg);
        r_s1   = $signed(rd_right_reg);
        up_s1  = $signed(rd_up_reg);
        dn_s1  = s1_reg.sample;
        ax_s1  = 35'(c_s1) + 35'(c_s1) - 35'(left_center_reg) - 35'(r_s1);
        ay_s1  = 35'(c_s1) + 35'(c_s1) - 35'(up_s1) - 35'(dn_s1);
        dx_raw = 33'(r_s1) - 33'(left_center_reg);
        dy_raw = 33'(dn_s1) - 33'(up_s1);
        dx_sat = sat32(56'(dx_raw));
        dy_sat = sat32(56'(dy_raw));
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_reg        <= s1_reg;
            s2_reg.center <= c_s1;
            ax_reg        <= ax_s1;
            ay_reg        <= ay_s1;
            dx_mag_reg    <= dx_sat[DATA_W-1] ? (~dx_sat + 32'd1) : dx_sat;
            dy_mag_reg    <= dy_sat[DATA_W-1] ? (~dy_sat + 32'd1) : dy_sat;
        end
    end

    // Stage 2: scale products and squared differences
    logic signed [55:0] px_reg, py_reg;
    logic [63:0]        sqx_reg, sqy_reg;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            s3_reg  <= s2_reg;
            px_reg  <= ax_reg * $signed({1'b0, scale_x_reg});
            py_reg  <= ay_reg * $signed({1'b0, scale_y_reg});
            sqx_reg <= 64'(dx_mag_reg) * 64'(dx_mag_reg);
            sqy_reg <= 64'(dy_mag_reg) * 64'(dy_mag_reg);
        end
    end

    // Stage 3: saturate, laplacian sum, scaled-down squares
    logic signed [DATA_W-1:0] uxx_s3, uyy_s3;
    logic signed [DATA_W-1:0] lap_reg;
    logic [30:0]              gsx_reg, gsy_reg;

    always_comb begin
        uxx_s3 = sat32(px_reg);
        uyy_s3 = sat32(py_reg);
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg) begin
            s4_reg  <= s3_reg;
            lap_reg <= sat32(56'(uxx_s3) + 56'(uyy_s3));
            gsx_reg <= (|sqx_reg[63:49]) ? '1 : sqx_reg[48:18];
            gsy_reg <= (|sqy_reg[63:49]) ? '1 : sqy_reg[48:18];
        end
    end

    // Stage 4: u times laplacian, gradient terms times scale
    logic signed [63:0] prod_reg;
    logic [50:0]        gx_reg, gy_reg;

    always_ff @(posedge aclk) begin
        if (s4_valid_reg) begin
            s5_reg   <= s4_reg;
            prod_reg <= 64'(s4_reg.center) * 64'(lap_reg);
            gx_reg   <= 51'(gsx_reg) * 51'(scale_x_reg);
            gy_reg   <= 51'(gsy_reg) * 51'(scale_y_reg);
        end
    end

    // Stage 5: combine and saturate
    logic signed [55:0]       t1_s5, diff_s5;
    logic [51:0]              g_s5;
    logic [53:0]              g3_s5;
    logic signed [DATA_W-1:0] res_above;
    result_t                  ent_above, ent_own, ent_first;
    logic [1:0]               push_n;

    always_comb begin
        t1_s5     = -56'($signed(prod_reg[63:16]));
        g_s5      = 52'(gx_reg) + 52'(gy_reg);
        g3_s5     = 54'(g_s5) + {1'b0, g_s5, 1'b0};
        diff_s5   = t1_s5 - $signed({2'b00, g3_s5});
        res_above = s5_reg.boundary ? s5_reg.center : sat32(diff_s5);

        ent_above.residual     = res_above;
        ent_above.row_index    = s5_reg.row - ROW_W'(1);
        ent_above.column_index = s5_reg.col;
        ent_above.run_last     = !s5_reg.emit_own;
        ent_above.grid_done    = 1'b0;

        ent_own.residual       = s5_reg.sample;
        ent_own.row_index      = s5_reg.row;
        ent_own.column_index   = s5_reg.col;
        ent_own.run_last       = 1'b1;
        ent_own.grid_done      = s5_reg.last_col;

        ent_first = s5_reg.emit_above ? ent_above : ent_own;
        push_n    = s5_valid_reg ? (2'(s5_reg.emit_above) + 2'(s5_reg.emit_own)) : 2'd0;
    end

    // Output queue
    result_t q_mem [Q_DEPTH];

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[q_tail_reg] <= ent_first;
        end
        if (push_n == 2'd2) begin
            q_mem[q_tail_reg + Q_AW'(1)] <= ent_own;
        end
    end

    always_comb begin
        q_count_next = q_count_reg + (Q_AW + 1)'(push_n) - (Q_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_count_reg <= '0;
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
        end else begin
            q_count_reg <= q_count_next;
            q_tail_reg  <= q_tail_reg + Q_AW'(push_n);
            if (pop) begin
                q_head_reg <= q_head_reg + Q_AW'(1);
            end
        end
    end

    // Result beat
    result_t head;

    always_comb begin
        head     = q_mem[q_head_reg];
        m_tvalid = (q_count_reg != '0);
        m_tdata  = M_TDATA_W'({head.column_index, head.row_index, head.residual});
        m_tlast  = head.run_last;
        m_tuser  = head.grid_done;
    end

endmodule

`default_nettype wire

FILE: rtl/nsr_checker.sv
// Port-level checker for the stencil residual block, bound to the top level.
`default_nettype none

module nsr_checker
    import nsr_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tlast,
    input wire logic [0:0]            m_tuser
);

    // Queue comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One sample in flight: ready drops after every accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample taken while one is in flight");

    // Grid end is always the last result of its sample
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("grid_done without run_last");

    // Grid end sits on a row past the first two
    a_done_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[M_ROW_LSB +: ROW_W] > ROW_W'(1)))
        else $error("grid_done on an early row");

    // Stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("result beat changed under stall");

endmodule

bind nonlinear_stencil_residual nsr_checker u_nsr_checker (.*);

`default_nettype wire
